@@ src/coa_pkg.sv @@
// Shared types and constants for the circle overlap area block.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package coa_pkg;

	localparam int DIV_STEPS    = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int CORDIC_STEPS = 30;
	// pipeline depth of one segment lane, from its input register to its term register
	localparam int LANE_LAT     = DIV_STEPS + SQRT_STEPS + CORDIC_STEPS + 10;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [39:0] AREA_MAX = 40'hFF_FFFF_FFFF;

	localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
		30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
		30'd31, 30'd15, 30'd7, 30'd3, 30'd1
	};

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_CONTAIN = 2'd1,
		KIND_LENS    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [23:0] distance;
		logic [47:0] distance_sq;
		logic [23:0] radius_a;
		logic [23:0] radius_b;
		logic        pair_last;
	} pair_t;

	typedef struct packed {
		logic [39:0] overlap_area;
		kind_t       overlap_kind;
		logic        last_out;
	} result_t;

	// classified pair, as held in the queue between front and back
	typedef struct packed {
		kind_t       kind;
		logic        a_is_min;
		logic [47:0] ra2;
		logic [47:0] rb2;
		logic [47:0] da;
		logic [47:0] db;
		logic [47:0] d2;
		logic        last;
	} class_t;

	typedef struct packed {
		logic        neg;
		logic [47:0] r2;
		logic        force_pi;
	} lane_side_t;

	typedef struct packed {
		kind_t kind;
		logic  last;
	} back_tag_t;

endpackage

`default_nettype wire

@@ src/coa_front.sv @@
// Front end: takes pairs, classifies them and forms the squared and product terms.
// Depends on coa_pkg.
`default_nettype none

module coa_front import coa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pair_valid,
	input  pair_t  pair,
	output logic   pair_ready,
	output logic   cls_valid,
	output class_t cls,
	input  logic   cls_ready
);

	logic        fen;
	logic        s1_valid;
	pair_t       pair_s1;
	logic [24:0] rsum;
	logic [23:0] rmin;
	logic [23:0] rmax;
	logic        a_min;
	logic        overlap;
	logic        contained;
	kind_t       kind;

	assign fen        = !cls_valid || cls_ready;
	assign pair_ready = fen;

	always_comb begin
		a_min     = pair_s1.radius_a < pair_s1.radius_b;
		rmin      = a_min ? pair_s1.radius_a : pair_s1.radius_b;
		rmax      = a_min ? pair_s1.radius_b : pair_s1.radius_a;
		rsum      = {1'b0, pair_s1.radius_a} + {1'b0, pair_s1.radius_b};
		overlap   = {1'b0, pair_s1.distance} < rsum;
		contained = ({1'b0, pair_s1.distance} + {1'b0, rmin}) <= {1'b0, rmax};
		if (!overlap) begin
			kind = KIND_NONE;
		end else if (contained) begin
			kind = KIND_CONTAIN;
		end else begin
			kind = KIND_LENS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			cls_valid <= 1'b0;
		end else if (fen) begin
			s1_valid  <= pair_valid;
			cls_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			pair_s1      <= pair;
			cls.kind     <= kind;
			cls.a_is_min <= a_min;
			cls.ra2      <= pair_s1.radius_a * pair_s1.radius_a;
			cls.rb2      <= pair_s1.radius_b * pair_s1.radius_b;
			cls.da       <= pair_s1.radius_a * pair_s1.distance;
			cls.db       <= pair_s1.radius_b * pair_s1.distance;
			cls.d2       <= pair_s1.distance_sq;
			cls.last     <= pair_s1.pair_last;
		end
	end

endmodule

`default_nettype wire

@@ src/coa_queue.sv @@
// Short FIFO between front and back so that each side stalls on its own.
// Depends on coa_pkg.
`default_nettype none

module coa_queue import coa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	input  class_t push_item,
	output logic   push_ready,
	output logic   pop_valid,
	input  logic   pop_ready,
	output class_t pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	class_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               push;
	logic               pop;

	assign push_ready = count_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

@@ src/coa_lane.sv @@
// One circular segment: cosine divide, sine root, CORDIC angle and r^2 scaling.
// Fully pipelined, one bit or one rotation per stage. Depends on coa_pkg.
`default_nettype none

module coa_lane import coa_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [50:0] num,
	input  logic        [48:0] den,
	input  logic        [47:0] r2,
	input  logic               force_pi,
	output logic        [39:0] term
);

	localparam int SH     = 30 + FRAC_BITS;
	localparam int ST_Q   = DIV_STEPS + 2;
	localparam int ST_SQ0 = ST_Q + 2;
	localparam int ST_CR  = ST_SQ0 + SQRT_STEPS;
	localparam int ST_M1  = ST_CR + CORDIC_STEPS + 1;
	localparam int SD_TOP = ST_M1 + 2;
	localparam int AC_N   = ST_M1 - ST_Q;
	localparam logic [80:0] ROUND = 81'(1) << (SH - 1);
	localparam logic [61:0] V_ONE = 62'(1) << 60;

	lane_side_t         sd [SD_TOP+1];
	logic        [50:0] a_mag;
	logic        [48:0] a_den;
	logic        [49:0] dv_r [DIV_STEPS+1];
	logic        [29:0] dv_q [DIV_STEPS+1];
	logic        [48:0] dv_den [DIV_STEPS+1];
	logic               dv_clamp [DIV_STEPS+1];
	logic        [30:0] ac_next;
	logic        [30:0] ac_s [AC_N];
	logic        [61:0] sq_p;
	logic        [61:0] sr_v [SQRT_STEPS+1];
	logic        [61:0] sr_res [SQRT_STEPS+1];
	logic signed [32:0] cx [1:CORDIC_STEPS-1];
	logic signed [32:0] cy [1:CORDIC_STEPS-1];
	logic signed [32:0] cz [1:CORDIC_STEPS];
	logic        [30:0] s_s [1:CORDIC_STEPS];
	logic        [61:0] mp;
	logic        [33:0] th_m1;
	logic        [33:0] th_m2;
	logic        [32:0] prod_m2;
	logic        [34:0] sc;
	logic        [34:0] g;
	logic        [31:0] fac_m3;
	logic        [55:0] lo_f1;
	logic        [55:0] hi_f1;
	logic        [80:0] full;
	logic        [80:0] shifted;

	assign ac_next = dv_clamp[DIV_STEPS] ? ONE_Q30 : {1'b0, dv_q[DIV_STEPS]};

	// side data and the sign fix-ups: a zero denominator gives +1, a zero cosine is not negative
	always_ff @(posedge clk) begin
		if (en) begin
			sd[0].neg      <= num[50];
			sd[0].r2       <= r2;
			sd[0].force_pi <= force_pi;
			for (int k = 1; k <= SD_TOP; k++) begin
				if (k == 1) begin
					sd[k].neg <= sd[0].neg && (a_den != '0);
				end else if (k == ST_Q) begin
					sd[k].neg <= sd[k-1].neg && (ac_next != '0);
				end else begin
					sd[k].neg <= sd[k-1].neg;
				end
				sd[k].r2       <= sd[k-1].r2;
				sd[k].force_pi <= sd[k-1].force_pi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_mag       <= num[50] ? 51'(-num) : 51'(num);
			a_den       <= den;
			dv_r[0]     <= a_mag[49:0];
			dv_q[0]     <= '0;
			dv_den[0]   <= a_den;
			dv_clamp[0] <= (a_den == '0) || (a_mag >= {2'b00, a_den});
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [50:0] t;
		logic        ge;
		assign t  = {dv_r[k], 1'b0};
		assign ge = t >= {2'b00, dv_den[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_r[k+1]     <= ge ? 50'(t - {2'b00, dv_den[k]}) : t[49:0];
				dv_q[k+1]     <= {dv_q[k][28:0], ge};
				dv_den[k+1]   <= dv_den[k];
				dv_clamp[k+1] <= dv_clamp[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s[0] <= ac_next;
			for (int m = 1; m < AC_N; m++) begin
				ac_s[m] <= ac_s[m-1];
			end
			sq_p      <= ac_s[0] * ac_s[0];
			sr_v[0]   <= V_ONE - sq_p;
			sr_res[0] <= '0;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [61:0] B = 62'(1) << (60 - 2 * j);
		logic [61:0] tmp;
		logic        ge;
		assign tmp = sr_res[j] + B;
		assign ge  = sr_v[j] >= tmp;
		always_ff @(posedge clk) begin
			if (en) begin
				sr_v[j+1]   <= ge ? sr_v[j] - tmp : sr_v[j];
				sr_res[j+1] <= ge ? (sr_res[j] >> 1) + B : sr_res[j] >> 1;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [32:0] xi;
		logic signed [32:0] yi;
		logic signed [32:0] zi;
		logic        [30:0] si;
		logic signed [32:0] xs;
		logic signed [32:0] ys;
		logic signed [32:0] at;
		if (i == 0) begin : g_init
			assign xi = $signed({2'b00, ac_s[ST_CR-ST_Q]});
			assign yi = $signed({2'b00, sr_res[SQRT_STEPS][30:0]});
			assign zi = '0;
			assign si = sr_res[SQRT_STEPS][30:0];
		end else begin : g_next
			assign xi = cx[i];
			assign yi = cy[i];
			assign zi = cz[i];
			assign si = s_s[i];
		end
		assign xs = xi >>> i;
		assign ys = yi >>> i;
		assign at = $signed({3'b000, ATAN_Q30[i]});
		if (i < CORDIC_STEPS - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (en) begin
					cx[i+1] <= yi[32] ? xi - ys : xi + ys;
					cy[i+1] <= yi[32] ? yi + xs : yi - xs;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cz[i+1]  <= yi[32] ? zi - at : zi + at;
				s_s[i+1] <= si;
			end
		end
	end

	always_comb begin
		sc = sd[ST_M1+1].neg ? 35'(-{2'b00, prod_m2}) : {2'b00, prod_m2};
		g  = {th_m2[33], th_m2} - sc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp      <= ac_s[AC_N-1] * s_s[CORDIC_STEPS];
			th_m1   <= sd[ST_M1-1].neg ? {2'b00, PI_Q30} - {cz[CORDIC_STEPS][32], cz[CORDIC_STEPS]}
			                           : {cz[CORDIC_STEPS][32], cz[CORDIC_STEPS]};
			prod_m2 <= 33'((mp + (62'(1) << 29)) >> 30);
			th_m2   <= th_m1;
			fac_m3  <= sd[ST_M1+1].force_pi ? PI_Q30 : (g[34] ? 32'd0 : g[31:0]);
			lo_f1   <= sd[SD_TOP].r2[23:0] * fac_m3;
			hi_f1   <= sd[SD_TOP].r2[47:24] * fac_m3;
		end
	end

	always_comb begin
		full    = {1'b0, hi_f1, 24'd0} + {25'd0, lo_f1} + ROUND;
		shifted = full >> SH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term <= (|shifted[80:40]) ? AREA_MAX : shifted[39:0];
		end
	end

endmodule

`default_nettype wire

@@ src/coa_back.sv @@
// Back end: forms cosine numerators, runs both segment lanes, sums and saturates.
// Depends on coa_pkg and coa_lane.
`default_nettype none

module coa_back import coa_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  class_t  q_item,
	output logic    q_ready,
	output logic    res_valid,
	output result_t res,
	input  logic    res_ready
);

	logic               ben;
	logic               tag_valid [LANE_LAT+1];
	back_tag_t          tag_s [LANE_LAT+1];
	logic signed [50:0] na_s1;
	logic signed [50:0] nb_s1;
	logic        [48:0] dna_s1;
	logic        [48:0] dnb_s1;
	logic        [47:0] r2a_s1;
	logic        [47:0] r2b_s1;
	logic               fpi_s1;
	logic        [39:0] term_a;
	logic        [39:0] term_b;
	logic        [40:0] sum;

	assign ben     = !res_valid || res_ready;
	assign q_ready = ben;
	assign sum     = {1'b0, term_a} + {1'b0, term_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LANE_LAT; k++) begin
				tag_valid[k] <= 1'b0;
			end
			res_valid <= 1'b0;
		end else if (ben) begin
			tag_valid[0] <= q_valid;
			for (int k = 1; k <= LANE_LAT; k++) begin
				tag_valid[k] <= tag_valid[k-1];
			end
			res_valid <= tag_valid[LANE_LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			tag_s[0].kind <= q_item.kind;
			tag_s[0].last <= q_item.last;
			for (int k = 1; k <= LANE_LAT; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
			nb_s1  <= $signed({3'b000, q_item.rb2} + {3'b000, q_item.d2} - {3'b000, q_item.ra2});
			na_s1  <= $signed({3'b000, q_item.ra2} + {3'b000, q_item.d2} - {3'b000, q_item.rb2});
			dnb_s1 <= {q_item.db, 1'b0};
			dna_s1 <= {q_item.da, 1'b0};
			fpi_s1 <= q_item.kind == KIND_CONTAIN;
			// containment runs through lane b with the smaller r^2 and a factor of pi
			if (q_item.kind == KIND_LENS) begin
				r2a_s1 <= q_item.ra2;
				r2b_s1 <= q_item.rb2;
			end else if (q_item.kind == KIND_CONTAIN) begin
				r2a_s1 <= '0;
				r2b_s1 <= q_item.a_is_min ? q_item.ra2 : q_item.rb2;
			end else begin
				r2a_s1 <= '0;
				r2b_s1 <= '0;
			end
			res.overlap_area <= sum[40] ? AREA_MAX : sum[39:0];
			res.overlap_kind <= tag_s[LANE_LAT].kind;
			res.last_out     <= tag_s[LANE_LAT].last;
		end
	end

	coa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
		.clk      (clk),
		.en       (ben),
		.num      (na_s1),
		.den      (dna_s1),
		.r2       (r2a_s1),
		.force_pi (1'b0),
		.term     (term_a)
	);

	coa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
		.clk      (clk),
		.en       (ben),
		.num      (nb_s1),
		.den      (dnb_s1),
		.r2       (r2b_s1),
		.force_pi (fpi_s1),
		.term     (term_b)
	);

endmodule

`default_nettype wire

@@ src/circle_overlap_area.sv @@
// Overlap area of two circles, one pair per transaction. A pair is accepted every
// cycle that the downstream side keeps up; the result is offered, at the earliest,
// once the pair has passed two front stages (the first loaded on the accepting edge),
// the four-entry queue, one numerator stage, the 101-stage segment lane and the
// output register. Each lane holds a 30-stage cosine divider, a 31-stage square root
// and a 30-stage CORDIC, each one bit or one rotation per stage. Results come out in
// order, one per pair.
// Depends on coa_pkg, coa_front, coa_queue and coa_back.
`default_nettype none

module circle_overlap_area import coa_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pair_valid,
	output logic    pair_ready,
	input  pair_t   pair,
	output logic    area_valid,
	input  logic    area_ready,
	output result_t area_result
);

	logic   cls_valid;
	logic   cls_ready;
	class_t cls;
	logic   q_valid;
	logic   q_ready;
	class_t q_item;

	coa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair       (pair),
		.pair_ready (pair_ready),
		.cls_valid  (cls_valid),
		.cls        (cls),
		.cls_ready  (cls_ready)
	);

	coa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid),
		.push_item  (cls),
		.push_ready (cls_ready),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	coa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_ready   (q_ready),
		.res_valid (area_valid),
		.res       (area_result),
		.res_ready (area_ready)
	);

endmodule

`default_nettype wire
